// File: rtl/bivms_pkg.sv
// Package: shared types, constants and opcodes for the pixel visit-mark store.
`timescale 1ns / 1ps
package bivms_pkg;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;
  localparam int CFG_W = 9;
  localparam int IDX_W = 1;

  localparam logic [IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [IDX_W-1:0] REG_COLS = 1'd1;

  localparam logic [2:0] K_WRITE = 3'd0;
  localparam logic [2:0] K_READ  = 3'd1;
  localparam logic [2:0] K_FIND  = 3'd2;
  localparam logic [2:0] K_NEIGH = 3'd3;
  localparam logic [2:0] K_CLEAR = 3'd4;
  localparam logic [2:0] K_ANY   = 3'd5;

  localparam logic [1:0] M_UNVIS = 2'd0;
  localparam logic [1:0] M_VIS   = 2'd1;
  localparam logic [1:0] M_EXCL  = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] row;
    logic [7:0] col;
    logic       pixel_on;
    logic [1:0] visit_mark;
    logic [7:0] prev_row;
    logic [7:0] prev_col;
    logic       include_excluded;
  } req_t;

  typedef struct packed {
    logic       range_error;
    logic       read_on;
    logic [1:0] read_mark;
    logic       found;
    logic [7:0] found_row;
    logic [7:0] found_col;
    logic [7:0] neighbour_mask;
    logic       axis_found;
    logic [2:0] axis_index;
    logic       aligned_found;
    logic [2:0] aligned_index;
  } rsp_t;

  // Decoded command handed from front to back.
  typedef struct packed {
    req_t        req;
    logic        in_range;
    logic [12:0] nr;
    logic [12:0] nc;
  } cmd_t;

endpackage

// File: rtl/bivms_if.sv
// Interface: valid/ready channel carrying one word.
`timescale 1ns / 1ps
interface bivms_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bivms_front.sv
// Front: accept requests, clamp sizes, check range, enqueue commands.
`timescale 1ns / 1ps
module bivms_front
  import bivms_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_req,
  output logic             q_valid,
  input  logic             q_ready,
  output cmd_t             q_cmd
);
  localparam int QD = 2;

  logic [CFG_W-1:0] image_rows, image_cols;
  logic [12:0] nr, nc;
  cmd_t q [QD];
  logic rd, wr;
  logic [1:0] cnt;
  logic wp, rp;
  cmd_t c;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= CFG_W'(256);
      image_cols <= CFG_W'(256);
    end else if (cfg_we) begin
      if (cfg_index == REG_ROWS) image_rows <= cfg_data;
      else image_cols <= cfg_data;
    end
  end

  always_comb begin
    nr = (32'(image_rows) > MAX_ROWS) ? 13'(MAX_ROWS) : 13'(image_rows);
    nc = (32'(image_cols) > MAX_COLS) ? 13'(MAX_COLS) : 13'(image_cols);
    c.req = in_req;
    c.nr = nr;
    c.nc = nc;
    c.in_range = (13'(in_req.row) < nr) && (13'(in_req.col) < nc);
  end

  assign in_ready = (cnt != 2'(QD));
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = q[rp];
  assign wr = in_valid && in_ready;
  assign rd = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (wr) q[wp] <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 2'(QD))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd0) |-> !q_valid)
    else $error("valid on empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> cnt == $past(cnt) + 2'd1)
    else $error("count slip");
endmodule

// File: rtl/bivms_back.sv
// Back: pixel memory and sequencer that executes each command.
`timescale 1ns / 1ps
module bivms_back
  import bivms_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_rsp
);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = RW + CW;
  localparam int DEPTH = 2 ** AW;

  typedef enum logic [7:0] {
    S_INIT = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_SCAN = 8'b0000_0100,
    S_SCHK = 8'b0000_1000,
    S_NRD  = 8'b0001_0000,
    S_NCHK = 8'b0010_0000,
    S_DONE = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } st_t;

  st_t st;
  logic [2:0] mem [DEPTH];
  logic [2:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic [2:0] wdata;
  logic we, re;
  cmd_t cmd;
  rsp_t rsp;
  rsp_t rsp_init;
  logic [12:0] sr, sc;
  logic [AW:0] clr;
  logic [3:0] k;
  logic [2:0] kp;
  logic kin, pin;
  logic signed [9:0] dr, dc, nrr, ncc;
  logic signed [9:0] pr_d, cr_d, pc_d, cc_d;
  logic signed [19:0] lhs, rhs;
  logic [12:0] nxt_c;
  logic last_c, last_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_comb begin
    case (k[2:0])
      3'd0: begin dr = -10'sd1; dc = -10'sd1; end
      3'd1: begin dr = -10'sd1; dc = 10'sd0; end
      3'd2: begin dr = -10'sd1; dc = 10'sd1; end
      3'd3: begin dr = 10'sd0;  dc = -10'sd1; end
      3'd4: begin dr = 10'sd0;  dc = 10'sd1; end
      3'd5: begin dr = 10'sd1;  dc = -10'sd1; end
      3'd6: begin dr = 10'sd1;  dc = 10'sd0; end
      default: begin dr = 10'sd1; dc = 10'sd1; end
    endcase
    nrr = $signed({2'b0, cmd.req.row}) + dr;
    ncc = $signed({2'b0, cmd.req.col}) + dc;
    kin = (nrr >= 0) && (ncc >= 0) && (13'(nrr[8:0]) < cmd.nr) && (13'(ncc[8:0]) < cmd.nc);
    nxt_c = sc + 13'd1;
    last_c = (nxt_c >= cmd.nc);
    last_r = (sr + 13'd1 >= cmd.nr);
  end

  always_comb begin
    rsp_init = '0;
    rsp_init.range_error = !q_cmd.in_range && (q_cmd.req.kind inside {K_WRITE, K_READ, K_NEIGH});
  end

  // Alignment products are registered from the pixel latched at issue.
  logic signed [9:0] ar, ac;
  always_comb begin
    pr_d = $signed({2'b0, cmd.req.prev_row}) - ar;
    cc_d = $signed({2'b0, cmd.req.col}) - ac;
    cr_d = $signed({2'b0, cmd.req.row}) - ar;
    pc_d = $signed({2'b0, cmd.req.prev_col}) - ac;
  end

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    re = 1'b0;
    raddr = '0;
    case (st)
      S_INIT: begin
        we = 1'b1;
        waddr = clr[AW-1:0];
        wdata = {1'b0, M_UNVIS};
      end
      S_IDLE: begin
        if (q_valid && q_cmd.req.kind == K_WRITE && q_cmd.in_range) begin
          we = 1'b1;
          waddr = {RW'(q_cmd.req.row), CW'(q_cmd.req.col)};
          wdata = {q_cmd.req.pixel_on,
                   (q_cmd.req.visit_mark == 2'd3) ? M_EXCL : q_cmd.req.visit_mark};
        end
        re = 1'b1;
        raddr = {RW'(q_cmd.req.row), CW'(q_cmd.req.col)};
      end
      S_SCAN: begin
        re = 1'b1;
        raddr = {sr[RW-1:0], sc[CW-1:0]};
      end
      S_SCHK: begin
        waddr = {sr[RW-1:0], sc[CW-1:0]};
        if (cmd.req.kind == K_FIND && rdata[1:0] == M_UNVIS && !rdata[2]) begin
          we = 1'b1;
          wdata = {rdata[2], M_VIS};
        end
        if (cmd.req.kind == K_CLEAR && rdata[1:0] == M_EXCL) begin
          we = 1'b1;
          wdata = {rdata[2], M_UNVIS};
        end
      end
      S_NRD: begin
        re = 1'b1;
        raddr = {RW'(nrr), CW'(ncc)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_INIT;
      clr <= '0;
      out_valid <= 1'b0;
    end else begin
      case (st)
        S_INIT: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(DEPTH - 1)) st <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            rsp <= rsp_init;
            sr <= '0;
            sc <= '0;
            k <= '0;
            case (q_cmd.req.kind)
              K_WRITE, K_READ, K_NEIGH: begin
                if (!q_cmd.in_range) begin
                  st <= S_OUT;
                  out_valid <= 1'b1;
                end else if (q_cmd.req.kind == K_NEIGH) st <= S_NRD;
                else if (q_cmd.req.kind == K_READ) st <= S_DONE;
                else begin
                  st <= S_OUT;
                  out_valid <= 1'b1;
                end
              end
              K_FIND, K_CLEAR, K_ANY: begin
                if (q_cmd.nr == 13'd0 || q_cmd.nc == 13'd0) begin
                  st <= S_OUT;
                  out_valid <= 1'b1;
                end else st <= S_SCAN;
              end
              default: begin
                st <= S_OUT;
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: st <= S_SCHK;
        S_SCHK: begin
          if (cmd.req.kind == K_FIND && rdata[1:0] == M_UNVIS && rdata[2]) begin
            rsp.found <= 1'b1;
            rsp.found_row <= sr[7:0];
            rsp.found_col <= sc[7:0];
            st <= S_OUT;
            out_valid <= 1'b1;
          end else if (cmd.req.kind == K_ANY && rdata[1:0] == M_UNVIS) begin
            rsp.found <= 1'b1;
            st <= S_OUT;
            out_valid <= 1'b1;
          end else if (last_c && last_r) begin
            st <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            st <= S_SCAN;
            if (last_c) begin
              sc <= '0;
              sr <= sr + 13'd1;
            end else sc <= nxt_c;
          end
        end
        S_NRD: begin
          pin <= kin;
          kp <= k[2:0];
          ar <= nrr;
          ac <= ncc;
          st <= S_NCHK;
        end
        S_NCHK: begin
          lhs <= pr_d * cc_d;
          rhs <= cr_d * pc_d;
          if (pin && rdata[2] && (cmd.req.include_excluded || rdata[1:0] != M_EXCL)) begin
            rsp.neighbour_mask[kp] <= 1'b1;
            if (!rsp.axis_found && (kp inside {3'd1, 3'd3, 3'd4, 3'd6})) begin
              rsp.axis_found <= 1'b1;
              rsp.axis_index <= kp;
            end
            k[3] <= 1'b1;
          end else k[3] <= 1'b0;
          st <= S_DONE;
        end
        S_DONE: begin
          if (cmd.req.kind == K_READ) begin
            rsp.read_on <= rdata[2];
            rsp.read_mark <= rdata[1:0];
            st <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            if (k[3] && !rsp.aligned_found && lhs == rhs) begin
              rsp.aligned_found <= 1'b1;
              rsp.aligned_index <= kp;
            end
            if (kp == 3'd7) begin
              st <= S_OUT;
              out_valid <= 1'b1;
            end else begin
              k <= {1'b0, kp + 3'd1};
              st <= S_NRD;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign q_ready = (st == S_IDLE);
  assign out_rsp = rsp;

  assert property (@(posedge clk) disable iff (rst) out_valid |-> st == S_OUT)
    else $error("result outside output state");
  assert property (@(posedge clk) disable iff (rst) (st == S_INIT) |-> !q_ready)
    else $error("accept during clear");
  assert property (@(posedge clk) disable iff (rst)
    (st == S_OUT && !out_ready) |=> st == S_OUT && $stable(out_rsp))
    else $error("result lost");
endmodule

// File: rtl/binary_image_visit_mark_store.sv
// Top level: binary image pixel store with visit marks.
`timescale 1ns / 1ps
// After reset a clearing pass writes every memory word's mark (65536 words by default)
// before the first word is taken. A neighbour query reads its eight neighbours one at a time
// through the single memory read port; find, clear and any-unvisited scans read one pixel
// at a time. A two-entry command queue lets requests be taken while a result waits.
module binary_image_visit_mark_store
  import bivms_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  bivms_if.sink            in_ch,
  bivms_if.source          out_ch
);
  logic q_valid, q_ready;
  cmd_t q_cmd;

  bivms_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req(in_ch.data),
    .q_valid, .q_ready, .q_cmd
  );

  bivms_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rsp(out_ch.data)
  );
endmodule

// File: tb/binary_image_visit_mark_store_tb.sv
// Testbench: binary_image_visit_mark_store against a scoreboard predictor, random words and idling.
`timescale 1ns / 1ps
module binary_image_visit_mark_store_tb;
  import bivms_pkg::*;

  localparam int IMG_MAX = 256;
  localparam int DR[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
  localparam int DC[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};

  class visit_mark_scoreboard;
    bit       on_px[IMG_MAX*IMG_MAX];
    bit [1:0] mark_px[IMG_MAX*IMG_MAX];
    bit       wr_px[IMG_MAX*IMG_MAX];
    int unsigned rows_reg = 256;
    int unsigned cols_reg = 256;
    rsp_t     expected_rsp[$];
    int       errors;
    int       n_words;
    int       n_checked;

    function int unsigned nr();
      return rows_reg > IMG_MAX ? IMG_MAX : rows_reg;
    endfunction

    function int unsigned nc();
      return cols_reg > IMG_MAX ? IMG_MAX : cols_reg;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_ROWS) rows_reg = 32'(val);
      else cols_reg = 32'(val);
    endfunction

    function bit in_img(int r, int c);
      return r >= 0 && c >= 0 && r < int'(nr()) && c < int'(nc());
    endfunction

    // true when every on bit the word would read has been written
    function bit on_reads_written(req_t q);
      int rr, cc;
      if (q.kind == K_READ)
        return !in_img(int'(q.row), int'(q.col)) || wr_px[q.row*IMG_MAX+q.col];
      if (q.kind == K_NEIGH) begin
        if (!in_img(int'(q.row), int'(q.col))) return 1'b1;
        for (int k = 0; k < 8; k++) begin
          rr = int'(q.row) + DR[k];
          cc = int'(q.col) + DC[k];
          if (in_img(rr, cc) && !wr_px[rr*IMG_MAX+cc]) return 1'b0;
        end
        return 1'b1;
      end
      if (q.kind == K_FIND) begin
        for (int r = 0; r < int'(nr()); r++)
          for (int c = 0; c < int'(nc()); c++)
            if (mark_px[r*IMG_MAX+c] == M_UNVIS) begin
              if (!wr_px[r*IMG_MAX+c]) return 1'b0;
              if (on_px[r*IMG_MAX+c]) return 1'b1;
            end
      end
      return 1'b1;
    endfunction

    function rsp_t predict(req_t q);
      rsp_t o;
      int a, rr, cc, pr, pc, cr, ccol;
      o = '0;
      case (q.kind)
        K_WRITE: begin
          if (!in_img(int'(q.row), int'(q.col))) o.range_error = 1'b1;
          else begin
            a = q.row*IMG_MAX + q.col;
            on_px[a] = q.pixel_on;
            mark_px[a] = (q.visit_mark == 2'd3) ? M_EXCL : q.visit_mark;
            wr_px[a] = 1'b1;
          end
        end
        K_READ: begin
          if (!in_img(int'(q.row), int'(q.col))) o.range_error = 1'b1;
          else begin
            a = q.row*IMG_MAX + q.col;
            o.read_on = on_px[a];
            o.read_mark = mark_px[a];
          end
        end
        K_FIND: begin
          for (int r = 0; r < int'(nr()) && !o.found; r++)
            for (int c = 0; c < int'(nc()) && !o.found; c++) begin
              a = r*IMG_MAX + c;
              if (mark_px[a] == M_UNVIS) begin
                if (on_px[a]) begin
                  o.found = 1'b1;
                  o.found_row = 8'(r);
                  o.found_col = 8'(c);
                end else mark_px[a] = M_VIS;
              end
            end
        end
        K_NEIGH: begin
          if (!in_img(int'(q.row), int'(q.col))) o.range_error = 1'b1;
          else begin
            cr = int'(q.row);
            ccol = int'(q.col);
            pr = int'(q.prev_row);
            pc = int'(q.prev_col);
            for (int k = 0; k < 8; k++) begin
              rr = cr + DR[k];
              cc = ccol + DC[k];
              if (!in_img(rr, cc)) continue;
              a = rr*IMG_MAX + cc;
              if (!on_px[a]) continue;
              if (!q.include_excluded && mark_px[a] == M_EXCL) continue;
              o.neighbour_mask[k] = 1'b1;
              if (!o.axis_found && (DR[k] == 0 || DC[k] == 0)) begin
                o.axis_found = 1'b1;
                o.axis_index = 3'(k);
              end
              if (!o.aligned_found && (pr - rr)*(ccol - cc) == (cr - rr)*(pc - cc)) begin
                o.aligned_found = 1'b1;
                o.aligned_index = 3'(k);
              end
            end
          end
        end
        K_CLEAR: begin
          for (int r = 0; r < int'(nr()); r++)
            for (int c = 0; c < int'(nc()); c++)
              if (mark_px[r*IMG_MAX+c] == M_EXCL) mark_px[r*IMG_MAX+c] = M_UNVIS;
        end
        K_ANY: begin
          for (int r = 0; r < int'(nr()) && !o.found; r++)
            for (int c = 0; c < int'(nc()); c++)
              if (mark_px[r*IMG_MAX+c] == M_UNVIS) o.found = 1'b1;
        end
        default: ;
      endcase
      return o;
    endfunction

    function void take_request(req_t q);
      expected_rsp.insert(expected_rsp.size(), predict(q));
      n_words++;
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none actual %h", $time, a);
        return;
      end
      e = expected_rsp.pop_front();
      n_checked++;
      if (a !== e) begin
        errors++;
        $display("%0t: result mismatch, expected %h actual %h", $time, e, a);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  bivms_if #(.T(req_t)) in_ch ();
  bivms_if #(.T(rsp_t)) out_ch ();

  visit_mark_scoreboard sb = new();
  bit quiet;
  int n_phases;

  always #1 clk = ~clk;

  binary_image_visit_mark_store u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  function int gap_len();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        stall = gap_len();
      end
    end
  end

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready) sb.check_response(out_ch.data);

  task send_word(req_t q);
    int g;
    g = gap_len();
    repeat (g) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data = q;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_request(q);
  endtask

  task drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task set_size(int r, int c);
    drain_results();
    write_reg(REG_ROWS, 9'(r));
    write_reg(REG_COLS, 9'(c));
    n_phases++;
  endtask

  function req_t mk(logic [2:0] k, int r, int c, bit on = 1'b0, logic [1:0] m = M_UNVIS,
                    int pr = 0, int pc = 0, bit incl = 1'b0);
    req_t q;
    q.kind = k;
    q.row = 8'(r);
    q.col = 8'(c);
    q.pixel_on = on;
    q.visit_mark = m;
    q.prev_row = 8'(pr);
    q.prev_col = 8'(pc);
    q.include_excluded = incl;
    return q;
  endfunction

  task send_safe(req_t q);
    if (!sb.on_reads_written(q)) q.kind = K_WRITE;
    send_word(q);
  endtask

  function int pick_pos(int lim, int centre);
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return $urandom_range(centre < 2 ? 0 : centre - 2, centre > 253 ? 255 : centre + 2);
    if (p < 85) return $urandom_range(0, lim > 255 ? 255 : lim);
    return $urandom_range(0, 255);
  endfunction

  task random_phase(int rows, int cols, int count);
    req_t q;
    int p;
    set_size(rows, cols);
    quiet = ($urandom_range(0, 3) == 0);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        if (!sb.wr_px[r*IMG_MAX+c])
          send_word(mk(K_WRITE, r, c, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))));
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      if (p < 30) q.kind = K_WRITE;
      else if (p < 45) q.kind = K_READ;
      else if (p < 62) q.kind = K_NEIGH;
      else if (p < 74) q.kind = K_FIND;
      else if (p < 81) q.kind = K_CLEAR;
      else if (p < 93) q.kind = K_ANY;
      else q.kind = 3'($urandom_range(6, 7));
      q.row = 8'(pick_pos(rows, $urandom_range(0, rows)));
      q.col = 8'(pick_pos(cols, $urandom_range(0, cols)));
      q.prev_row = 8'(pick_pos(rows, int'(q.row)));
      q.prev_col = 8'(pick_pos(cols, int'(q.col)));
      q.pixel_on = 1'($urandom_range(0, 1));
      q.visit_mark = ($urandom_range(0, 1) == 0) ? M_UNVIS : 2'($urandom_range(1, 3));
      q.include_excluded = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) == 0) drain_results();
      send_safe(q);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    quiet = 1'b1;
    send_safe(mk(K_ANY, 0, 0));
    send_safe(mk(K_WRITE, 0, 0, 1'b1, M_UNVIS));
    send_safe(mk(K_WRITE, 0, 1, 1'b0, 2'd3));
    send_safe(mk(K_WRITE, 1, 0, 1'b1, M_VIS));
    send_safe(mk(K_WRITE, 1, 1, 1'b1, M_EXCL));
    send_safe(mk(K_WRITE, 255, 255, 1'b1, M_EXCL));
    send_safe(mk(K_WRITE, 254, 254, 1'b1, M_UNVIS));
    send_safe(mk(K_WRITE, 254, 255, 1'b0, M_VIS));
    send_safe(mk(K_WRITE, 255, 254, 1'b1, M_EXCL));
    send_safe(mk(K_READ, 0, 1));
    send_safe(mk(K_READ, 255, 255));
    send_safe(mk(K_NEIGH, 0, 0, 1'b0, M_UNVIS, 0, 0, 1'b0));
    send_safe(mk(K_NEIGH, 0, 0, 1'b0, M_UNVIS, 2, 2, 1'b1));
    send_safe(mk(K_NEIGH, 255, 255, 1'b0, M_UNVIS, 253, 253, 1'b1));
    send_safe(mk(K_NEIGH, 255, 255, 1'b0, M_UNVIS, 255, 0, 1'b0));
    send_safe(mk(K_FIND, 0, 0));
    send_safe(mk(3'd6, 255, 255, 1'b1, 2'd3, 255, 255, 1'b1));
    send_safe(mk(3'd7, 0, 0));
    send_safe(mk(K_CLEAR, 0, 0));
    send_safe(mk(K_READ, 1, 1));

    set_size(0, 0);
    send_safe(mk(K_WRITE, 0, 0, 1'b1, M_VIS));
    send_safe(mk(K_READ, 0, 0));
    send_safe(mk(K_NEIGH, 0, 0));
    send_safe(mk(K_FIND, 0, 0));
    send_safe(mk(K_ANY, 0, 0));
    send_safe(mk(K_CLEAR, 0, 0));

    set_size(511, 511);
    send_safe(mk(K_READ, 255, 254));
    send_safe(mk(K_NEIGH, 255, 255, 1'b0, M_UNVIS, 255, 255, 1'b1));

    random_phase(1, 1, 100);
    random_phase(2, 3, 130);
    random_phase(4, 4, 130);
    random_phase(8, 8, 150);
    random_phase(3, 12, 130);
    random_phase(16, 2, 120);
    random_phase(16, 16, 160);
    random_phase(5, 7, 130);
    random_phase(1, 9, 100);

    drain_results();
    $display("covered %0d words, %0d results checked over %0d size settings",
             sb.n_words, sb.n_checked, n_phases);
    $display("sizes from empty to full, every kind, random idling on both channels");
    if (sb.errors == 0 && sb.expected_rsp.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", sb.expected_rsp.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
